[rtl/color_range_threshold_hsl_core_macros.svh]
// Assertion macros used by the color threshold divider pipeline.
`ifndef COLOR_RANGE_THRESHOLD_HSL_CORE_MACROS_SVH
`define COLOR_RANGE_THRESHOLD_HSL_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crt check failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crt check failed: next-cycle implication");

`endif

[rtl/crt_pkg.sv]
// Types, constants and the divider step shared by the color threshold pipeline.
`timescale 1ns / 1ps
`default_nettype none
package crt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int REM_W     = 19;   // 255 * 5c for c up to 255
  localparam int DEN_W     = 11;   // 6c for c up to 255
  localparam int QUOT_W    = 8;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUOT_W / BITS_PER_STAGE;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_HIGH  = 3'd6;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] quot;
  } crt_lane_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] light;
    logic       czero;   // max == min: hue and saturation forced to zero
    logic       neg;     // red sector with green below blue
    crt_lane_t  sat;
    crt_lane_t  hue;
  } crt_item_t;

  typedef struct packed {
    logic       color_mode;
    logic [7:0] first_low;
    logic [7:0] first_high;
    logic [7:0] second_low;
    logic [7:0] second_high;
    logic [7:0] third_low;
    logic [7:0] third_high;
  } crt_cfg_t;

  // Restoring division, quotient bits hi_bit down to hi_bit-1.
  function automatic crt_lane_t div_steps(crt_lane_t lane, logic [2:0] hi_bit);
    crt_lane_t        res;
    logic [REM_W-1:0] trial;
    logic [2:0]       pos;
    res = lane;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      pos   = hi_bit - 3'(k);
      trial = REM_W'(res.den) << pos;
      if (res.rem >= trial) begin
        res.rem       = res.rem - trial;
        res.quot[pos] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/crt_front.sv]
// First stage: max/min, lightness and the two division operands.
`timescale 1ns / 1ps
`default_nettype none
module crt_front
  import crt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pix_valid,
  output logic            pix_stall,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic            item_valid,
  input  wire logic       item_stall,
  output crt_item_t       item
);

  logic [7:0]  mx, mn, c;
  logic [8:0]  sum;
  logic [7:0]  sat_den;
  logic [10:0] y;
  logic        neg;
  logic        adv;
  crt_item_t   item_next;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    c   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    sat_den = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    neg = 1'b0;
    if (red >= green && red >= blue) begin
      neg = green < blue;
      y   = neg ? 11'(blue - green) : 11'(green - blue);
    end else if (green >= blue) begin
      y = 11'({c, 1'b0}) + 11'(blue) - 11'(red);
    end else begin
      y = 11'({c, 2'b00}) + 11'(red) - 11'(green);
    end
    item_next.red      = red;
    item_next.green    = green;
    item_next.blue     = blue;
    item_next.light    = sum[8:1];
    item_next.czero    = (c == 8'd0);
    item_next.neg      = neg;
    item_next.sat.rem  = REM_W'({c, 8'h00}) - REM_W'(c);      // 255 * c
    item_next.sat.den  = DEN_W'(sat_den);
    item_next.sat.quot = '0;
    item_next.hue.rem  = REM_W'({y, 8'h00}) - REM_W'(y);      // 255 * y
    item_next.hue.den  = DEN_W'({c, 2'b00}) + DEN_W'({c, 1'b0});  // 6c
    item_next.hue.quot = '0;
  end

  assign adv       = !item_valid || !item_stall;
  assign pix_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (adv) begin
      item_valid <= pix_valid;
    end
    if (adv && pix_valid) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

[rtl/crt_div_pipe.sv]
// Four-stage restoring divider pair: saturation and hue quotients, two bits a stage.
`timescale 1ns / 1ps
`default_nettype none
`include "color_range_threshold_hsl_core_macros.svh"
module crt_div_pipe
  import crt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire crt_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output crt_item_t      out_item
);

  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES-1:0] adv;
  crt_item_t             stage [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      crt_item_t src;
      crt_item_t nxt;
      logic      src_valid;

      if (k == 0) begin : g_head
        assign src       = in_item;
        assign src_valid = in_valid;
      end else begin : g_body
        assign src       = stage[k-1];
        assign src_valid = v[k-1];
      end

      if (k == DIV_STAGES - 1) begin : g_tail
        assign adv[k] = !v[k] || !out_stall;
      end else begin : g_mid
        assign adv[k] = !v[k] || adv[k+1];
      end

      always_comb begin
        nxt     = src;
        nxt.sat = div_steps(src.sat, 3'(QUOT_W - 1 - BITS_PER_STAGE * k));
        nxt.hue = div_steps(src.hue, 3'(QUOT_W - 1 - BITS_PER_STAGE * k));
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (adv[k]) begin
          v[k] <= src_valid;
        end
        if (adv[k] && src_valid) begin
          stage[k] <= nxt;
        end
      end
    end
  endgenerate

  assign in_stall  = !adv[0];
  assign out_valid = v[DIV_STAGES-1];
  assign out_item  = stage[DIV_STAGES-1];

  // Finished quotients leave a remainder below the divisor.
  `CRT_ASSERT_IMPL(a_hue_rem, clk, rst, out_valid && out_item.hue.den != '0, out_item.hue.rem < REM_W'(out_item.hue.den))
  `CRT_ASSERT_IMPL(a_sat_rem, clk, rst, out_valid && out_item.sat.den != '0, out_item.sat.rem < REM_W'(out_item.sat.den))
  // An empty first stage always takes a transfer.
  `CRT_ASSERT_IMPL(a_head_free, clk, rst, !v[0], !in_stall)
  // A held result keeps its quotients.
  `CRT_ASSERT_NEXT(a_tail_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item.hue.quot) && $stable(out_item.sat.quot))

endmodule
`default_nettype wire

[rtl/crt_back.sv]
// Last stage: hue wrap, mode select, range checks and the output register.
`timescale 1ns / 1ps
`default_nettype none
module crt_back
  import crt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire crt_cfg_t  cfg,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire crt_item_t in_item,
  output logic           mask_valid,
  input  wire logic      mask_stall,
  output logic           pixel_white
);

  logic [7:0] hue, sat;
  logic [7:0] a, m, z;
  logic       ok;
  logic       adv;

  always_comb begin
    if (in_item.czero) begin
      hue = 8'd0;
    end else if (in_item.neg && in_item.hue.quot != 8'd0) begin
      hue = 8'd255 - in_item.hue.quot;   // negative red-sector hue wraps
    end else begin
      hue = in_item.hue.quot;
    end
    sat = in_item.czero ? 8'd0 : in_item.sat.quot;
    if (cfg.color_mode) begin
      a = hue;
      m = sat;
      z = in_item.light;
    end else begin
      a = in_item.red;
      m = in_item.green;
      z = in_item.blue;
    end
    ok = (a >= cfg.first_low)  && (a <= cfg.first_high) &&
         (m >= cfg.second_low) && (m <= cfg.second_high) &&
         (z >= cfg.third_low)  && (z <= cfg.third_high);
  end

  assign adv      = !mask_valid || !mask_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= 1'b0;
    end else if (adv) begin
      mask_valid <= in_valid;
    end
    if (adv && in_valid) begin
      pixel_white <= ok;
    end
  end

endmodule
`default_nettype wire

[rtl/color_range_threshold_hsl_core.sv]
// Top level: configuration registers and the six-stage threshold pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Color range threshold: takes one 8-bit RGB pixel per clock while pix_stall is
// low and returns a one-bit mask, 1 when all three channels (raw RGB, or
// hue/saturation/lightness when color_mode is 1) lie inside their inclusive
// low..high ranges. Each pixel passes one stage for max/min and operands, four
// stages for the two restoring dividers (hue and saturation, two quotient bits per
// stage) and one stage for the range checks before its mask is valid. A stall on
// the mask side fills the pipeline stage by stage before pix_stall rises.
// Configuration writes are always accepted (cfg_ready is always high) and must be
// made while no pixel is in flight.
module color_range_threshold_hsl_core
  import crt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pix_valid,
  output logic                      pix_stall,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  output logic                      mask_valid,
  input  wire logic                 mask_stall,
  output logic                      pixel_white,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  crt_cfg_t  cfg;
  crt_item_t front_item, div_item;
  logic      front_valid, front_stall;
  logic      div_valid, div_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_mode  <= 1'b1;
      cfg.first_low   <= 8'd0;
      cfg.first_high  <= 8'd255;
      cfg.second_low  <= 8'd0;
      cfg.second_high <= 8'd255;
      cfg.third_low   <= 8'd0;
      cfg.third_high  <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLOR_MODE:  cfg.color_mode  <= cfg_data[0];
        CFG_FIRST_LOW:   cfg.first_low   <= cfg_data;
        CFG_FIRST_HIGH:  cfg.first_high  <= cfg_data;
        CFG_SECOND_LOW:  cfg.second_low  <= cfg_data;
        CFG_SECOND_HIGH: cfg.second_high <= cfg_data;
        CFG_THIRD_LOW:   cfg.third_low   <= cfg_data;
        CFG_THIRD_HIGH:  cfg.third_high  <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  crt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .item_valid (front_valid),
    .item_stall (front_stall),
    .item       (front_item)
  );

  crt_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .in_item   (front_item),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .out_item  (div_item)
  );

  crt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (div_valid),
    .in_stall    (div_stall),
    .in_item     (div_item),
    .mask_valid  (mask_valid),
    .mask_stall  (mask_stall),
    .pixel_white (pixel_white)
  );

endmodule
`default_nettype wire

[verif/color_range_threshold_hsl_checker.sv]
// Scoreboard for the color threshold core: mirrors the registers and checks each mask.
`timescale 1ns / 1ps
module color_range_threshold_hsl_checker
  import crt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  input  logic                 pix_stall,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic                 mask_valid,
  input  logic                 mask_stall,
  input  logic                 pixel_white,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatch_count = 0,
  output int                   pending = 0
);

  crt_cfg_t regs;
  logic     white_expected[$];

  function automatic bit in_window(int v, logic [7:0] lo, logic [7:0] hi);
    return v >= int'(lo) && v <= int'(hi);
  endfunction

  // Mask for one pixel: raw channels, or hue/saturation/lightness on a 0..255 scale.
  function automatic logic predict_white(crt_cfg_t k, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
    int rv, gv, bv, mx, mn, c, sum, num, den, q;
    int a, m, z;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    a  = rv;
    m  = gv;
    z  = bv;
    if (k.color_mode) begin
      mx  = (rv > gv) ? rv : gv;
      mx  = (bv > mx) ? bv : mx;
      mn  = (rv < gv) ? rv : gv;
      mn  = (bv < mn) ? bv : mn;
      c   = mx - mn;
      sum = mx + mn;
      z   = sum / 2;
      a   = 0;
      m   = 0;
      if (c != 0) begin
        m   = (255 * c) / ((sum < 255) ? sum : (510 - sum));
        den = 6 * c;
        if (mx == rv) begin
          num = 255 * (gv - bv);
        end else if (mx == gv) begin
          num = 255 * (2 * c + bv - rv);
        end else begin
          num = 255 * (4 * c + rv - gv);
        end
        // integer division truncates toward zero; only the red sector goes negative
        q = num / den;
        if (q < 0) begin
          q = q + 255;
        end
        if (q >= 255) begin
          q = q - 255;
        end
        a = q;
      end
    end
    return in_window(a, k.first_low, k.first_high) &&
           in_window(m, k.second_low, k.second_high) &&
           in_window(z, k.third_low, k.third_high);
  endfunction

  always @(posedge clk) begin : watch
    logic want;
    if (rst) begin
      regs.color_mode  = 1'b1;
      regs.first_low   = 8'd0;
      regs.first_high  = 8'd255;
      regs.second_low  = 8'd0;
      regs.second_high = 8'd255;
      regs.third_low   = 8'd0;
      regs.third_high  = 8'd255;
      white_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLOR_MODE:  regs.color_mode  = cfg_data[0];
          CFG_FIRST_LOW:   regs.first_low   = cfg_data;
          CFG_FIRST_HIGH:  regs.first_high  = cfg_data;
          CFG_SECOND_LOW:  regs.second_low  = cfg_data;
          CFG_SECOND_HIGH: regs.second_high = cfg_data;
          CFG_THIRD_LOW:   regs.third_low   = cfg_data;
          CFG_THIRD_HIGH:  regs.third_high  = cfg_data;
          default: ;
        endcase
      end
      // retire the mask transfer before queueing this edge's pixel
      if (mask_valid && !mask_stall) begin
        if (white_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: pixel_white expected none, got %0b", $time, pixel_white);
        end else begin
          want = white_expected.pop_front();
          if (pixel_white !== want) begin
            mismatch_count++;
            $display("%0t: pixel_white expected %0b, got %0b", $time, want, pixel_white);
          end
        end
      end
      if (pix_valid && !pix_stall) begin
        white_expected.push_back(predict_white(regs, red, green, blue));
      end
    end
    pending = white_expected.size();
  end

endmodule

[verif/color_range_threshold_hsl_core_tb.sv]
// Testbench top for the color threshold core: pixel and register stimulus, verdict.
`timescale 1ns / 1ps
module color_range_threshold_hsl_core_tb;
  import crt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int MAX_WAIT    = 12;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES  = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [7:0]           red = 8'd0;
  logic [7:0]           green = 8'd0;
  logic [7:0]           blue = 8'd0;
  logic                 mask_valid;
  logic                 mask_stall = 1'b0;
  logic                 pixel_white;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'd0;
  int                   mismatch_count;
  int                   pending;

  int       cycles = 0;
  bit       no_idle = 1'b0;
  bit       hold_req = 1'b0;
  crt_cfg_t cur_cfg;

  // sector boundaries, gray, sum at and around 255, tiny and large chroma
  logic [23:0] corner_pixels [0:16] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hFF0001, 24'h010000, 24'hFEFFFF,
    24'h00FF80, 24'h00FE80, 24'hC83264, 24'h6432C8, 24'h7F7F7F
  };

  always #5 clk = ~clk;

  color_range_threshold_hsl_core u_dut (.*);

  color_range_threshold_hsl_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // mask side: random stall before each transfer, one long hold on request
  initial begin : mask_sink
    int w;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        mask_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (w > 0) begin
          mask_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      mask_stall <= 1'b0;
      do @(negedge clk); while (!mask_valid);
      @(posedge clk);
    end
  end

  function automatic crt_cfg_t make_cfg(logic mode, logic [7:0] l1, logic [7:0] h1,
                                        logic [7:0] l2, logic [7:0] h2,
                                        logic [7:0] l3, logic [7:0] h3);
    crt_cfg_t c;
    c.color_mode  = mode;
    c.first_low   = l1;
    c.first_high  = h1;
    c.second_low  = l2;
    c.second_high = h2;
    c.third_low   = l3;
    c.third_high  = h3;
    return c;
  endfunction

  // {low, high}: full span, empty (low above high), single value, or a random window
  function automatic logic [15:0] rand_bounds();
    int lo, hi;
    case ($urandom_range(0, 7))
      0: begin
        lo = 0;
        hi = 255;
      end
      1: begin
        lo = $urandom_range(1, 255);
        hi = $urandom_range(0, lo - 1);
      end
      2: begin
        lo = $urandom_range(0, 255);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(0, 180);
        hi = lo + $urandom_range(40, 255);
        if (hi > 255) begin
          hi = 255;
        end
      end
    endcase
    return {8'(lo), 8'(hi)};
  endfunction

  function automatic crt_cfg_t rand_cfg();
    crt_cfg_t c;
    c.color_mode = 1'($urandom_range(0, 1));
    {c.first_low, c.first_high}   = rand_bounds();
    {c.second_low, c.second_high} = rand_bounds();
    {c.third_low, c.third_high}   = rand_bounds();
    return c;
  endfunction

  function automatic logic [7:0] chan_in(logic [7:0] lo, logic [7:0] hi);
    return (lo <= hi) ? 8'($urandom_range(lo, hi)) : 8'($urandom);
  endfunction

  function automatic logic [23:0] pick_pixel();
    logic [7:0]  v, o;
    logic [23:0] px;
    case ($urandom_range(0, 9))
      0: begin
        v  = 8'($urandom);
        px = {v, v, v};
      end
      1: begin
        // two channels tie for the maximum
        v  = 8'($urandom);
        o  = 8'($urandom_range(0, v));
        px = {v, v, o};
        case ($urandom_range(0, 2))
          0: px = {v, o, v};
          1: px = {o, v, v};
          default: ;
        endcase
      end
      2: px = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
      3, 4: px = {chan_in(cur_cfg.first_low, cur_cfg.first_high),
                  chan_in(cur_cfg.second_low, cur_cfg.second_high),
                  chan_in(cur_cfg.third_low, cur_cfg.third_high)};
      default: px = 24'($urandom);
    endcase
    return px;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_cfg(input crt_cfg_t c);
    // upper bits of the mode write must be dropped
    cfg_write(CFG_COLOR_MODE, {7'($urandom), c.color_mode});
    cfg_write(CFG_FIRST_LOW, c.first_low);
    cfg_write(CFG_FIRST_HIGH, c.first_high);
    cfg_write(CFG_SECOND_LOW, c.second_low);
    cfg_write(CFG_SECOND_HIGH, c.second_high);
    cfg_write(CFG_THIRD_LOW, c.third_low);
    cfg_write(CFG_THIRD_HIGH, c.third_high);
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_UNUSED, 8'($urandom));
    end
    cur_cfg = c;
  endtask

  task automatic send_pixel(input logic [23:0] px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    red       <= px[23:16];
    green     <= px[15:8];
    blue      <= px[7:0];
    do @(negedge clk); while (pix_stall);
    @(posedge clk);
  endtask

  // stop offering pixels until every mask is back
  task automatic drain();
    pix_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input crt_cfg_t c, input int n, input bit pause);
    load_cfg(c);
    for (int i = 0; i < n; i++) begin
      if (pause && i == n / 2) begin
        drain();
      end
      send_pixel(pick_pixel());
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset state: HSL mode with full ranges
    cur_cfg = make_cfg(1'b1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    foreach (corner_pixels[i]) begin
      send_pixel(corner_pixels[i]);
    end
    drain();

    // extremes: empty red range, single value at either end
    run_phase(make_cfg(1'b0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255), 30, 1'b0);
    run_phase(make_cfg(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 30, 1'b0);
    run_phase(make_cfg(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 30, 1'b0);
    run_phase(make_cfg(1'b1, 8'd0, 8'd254, 8'd255, 8'd255, 8'd0, 8'd255), 30, 1'b0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      no_idle = (phase % 3 == 1) || (phase == 2);
      // phase 2 backs up the pipeline behind a long mask stall
      hold_req = (phase == 2);
      run_phase(rand_cfg(), PHASE_ITEMS, phase == 4);
    end
    no_idle = 1'b0;

    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
